@@ rtl/core/ssd_pkg.sv @@
// Shared types, codes and defaults for the seven-segment scan driver.
`default_nettype none

package ssd_pkg;

   // Default sizing of the display and its timing.
   localparam int DIGIT_COUNT_DEFAULT     = 4;
   localparam int TICKS_PER_DIGIT_DEFAULT = 5;
   localparam int BLINK_TICKS_DEFAULT     = 200;

   // Field widths of the request and response words.
   localparam int OP_W       = 3;
   localparam int DIGIT_W    = 3;
   localparam int PATTERN_W  = 8;
   localparam int SELECT_W   = 2;
   localparam int BRIGHT_W   = 4;
   localparam int WINDOW_W   = 4;
   localparam int BLINK_W    = 8;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   // Brightness after reset.
   localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 4'd5;

   // Request operation codes.
   typedef enum logic [OP_W-1:0] {
      OP_TICK        = 3'd0,
      OP_SET_PATTERN = 3'd1,
      OP_BLINK_ALL   = 3'd2,
      OP_BLINK_ONE   = 3'd3,
      OP_STOP_BLINK  = 3'd4,
      OP_ERASE       = 3'd5
   } op_type;

   // Status codes.
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_BAD_DIGIT = 1'b1;

   // One response word, segments in the lowest bits.
   typedef struct packed {
      logic                 status;
      logic [SELECT_W-1:0]  select;
      logic [PATTERN_W-1:0] segments;
   } rsp_word_type;

endpackage

`default_nettype wire

@@ rtl/core/ssd_out_buf.sv @@
// Response register with a skid stage so one more request can be taken under a stall.
`default_nettype none

module ssd_out_buf (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire ssd_pkg::rsp_word_type in_word,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output ssd_pkg::rsp_word_type      out_word
);
   import ssd_pkg::*;

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type out_word_ff, out_word_in;
   rsp_word_type skid_word_ff, skid_word_in;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_word  = out_word_ff;

   // Refill the output stage from the skid stage first, then from the input.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_word_in  = in_word;
         end
      end else if (in_valid && !skid_valid_ff) begin
         skid_valid_in = 1'b1;
         skid_word_in  = in_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

endmodule

`default_nettype wire

@@ rtl/core/seven_segment_scan_blink_dimmer.sv @@
// Top level: multiplexed seven-segment scan driver with blink and dimming.
//
//  channel | direction | handshake           | word
//  req     | in        | req_tvalid/tready   | op, digit, pattern, enable
//  rsp     | out       | rsp_tvalid/tready   | segments, select, status
//  csr     | in        | csr_valid/ready     | brightness
//
// The display state and the response word are both registered at the edge that
// accepts a request; the word goes to the output or, under a stall, the skid register.
// The two-entry output buffer takes one request per cycle while the response side is
// ready and one more while it stalls; requests stop only when both entries are full.
// Reset is synchronous and blanks every digit, stops blinking and sets brightness to 5.
`default_nettype none

module seven_segment_scan_blink_dimmer #(
   parameter int DIGIT_COUNT     = ssd_pkg::DIGIT_COUNT_DEFAULT,
   parameter int TICKS_PER_DIGIT = ssd_pkg::TICKS_PER_DIGIT_DEFAULT,
   parameter int BLINK_TICKS     = ssd_pkg::BLINK_TICKS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // op[2:0], digit[5:3], pattern[13:6], enable[14], zero[15]
   input  wire logic [ssd_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // segments[7:0], select[9:8], status[10], zero[15:11]
   output logic [ssd_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [ssd_pkg::BRIGHT_W-1:0]     csr_wdata
);
   import ssd_pkg::*;

   localparam int CUR_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
   localparam logic [CUR_W-1:0]    CUR_LAST  = CUR_W'(DIGIT_COUNT - 1);
   localparam logic [WINDOW_W-1:0] WIN_LOAD  = WINDOW_W'(TICKS_PER_DIGIT);
   localparam logic [BLINK_W-1:0]  BLINK_LOAD = BLINK_W'(BLINK_TICKS);
   localparam logic [DIGIT_W:0]    DIGIT_LIMIT = (DIGIT_W+1)'(DIGIT_COUNT);

   // Unpack the request word.
   op_type               req_op;
   logic [DIGIT_W-1:0]   req_digit;
   logic [PATTERN_W-1:0] req_pattern;
   logic                 req_enable;

   assign req_op      = op_type'(req_tdata[2:0]);
   assign req_digit   = req_tdata[5:3];
   assign req_pattern = req_tdata[13:6];
   assign req_enable  = req_tdata[14];

   // Display state.
   logic [PATTERN_W-1:0] pattern_ff   [DIGIT_COUNT];
   logic [PATTERN_W-1:0] pattern_in   [DIGIT_COUNT];
   logic [BLINK_W-1:0]   blink_cnt_ff [DIGIT_COUNT];
   logic [BLINK_W-1:0]   blink_cnt_in [DIGIT_COUNT];
   logic [DIGIT_COUNT-1:0] blink_en_ff, blink_en_in;
   logic [DIGIT_COUNT-1:0] phase_ff, phase_in;
   logic [CUR_W-1:0]     cur_ff, cur_in;
   logic [BRIGHT_W-1:0]  lit_ff, lit_in;
   logic [WINDOW_W-1:0]  win_ff, win_in;
   logic [PATTERN_W-1:0] seg_ff, seg_in;
   logic [SELECT_W-1:0]  sel_ff, sel_in;
   logic [BRIGHT_W-1:0]  bright_ff;

   logic                 accept;
   logic                 digit_ok;
   logic                 status;
   logic [2:0]           cur_wide;
   rsp_word_type         rsp_word;
   rsp_word_type         rsp_word_out;

   assign accept    = req_tvalid && req_tready;
   assign digit_ok  = {1'b0, req_digit} < DIGIT_LIMIT;
   assign cur_wide  = 3'(cur_ff);
   assign csr_ready = 1'b1;

   // Compute the next display state for the accepted word.
   always_comb begin
      pattern_in   = pattern_ff;
      blink_cnt_in = blink_cnt_ff;
      blink_en_in  = blink_en_ff;
      phase_in     = phase_ff;
      cur_in       = cur_ff;
      lit_in       = lit_ff;
      win_in       = win_ff;
      seg_in       = seg_ff;
      sel_in       = sel_ff;
      status       = STATUS_OK;
      case (req_op)
         OP_TICK: begin
            // Drive the current digit, then advance the scan counters.
            seg_in = (phase_ff[cur_ff] && lit_ff != '0) ? pattern_ff[cur_ff] : '0;
            sel_in = cur_wide[SELECT_W-1:0];
            if (lit_ff != '0) begin
               lit_in = lit_ff - 1'b1;
            end
            if (win_ff <= WINDOW_W'(1)) begin
               cur_in = (cur_ff == CUR_LAST) ? '0 : cur_ff + 1'b1;
               win_in = WIN_LOAD;
               lit_in = bright_ff;
            end else begin
               win_in = win_ff - 1'b1;
            end
            // Advance the blink counter of the digit now current.
            for (int i = 0; i < DIGIT_COUNT; i++) begin
               if (cur_in == CUR_W'(i) && blink_en_ff[i]) begin
                  if (blink_cnt_ff[i] <= BLINK_W'(1)) begin
                     blink_cnt_in[i] = BLINK_LOAD;
                     phase_in[i]     = !phase_ff[i];
                  end else begin
                     blink_cnt_in[i] = blink_cnt_ff[i] - 1'b1;
                  end
               end
            end
         end
         OP_SET_PATTERN: begin
            if (digit_ok) begin
               for (int i = 0; i < DIGIT_COUNT; i++) begin
                  if (req_digit == DIGIT_W'(i)) begin
                     pattern_in[i] = req_pattern;
                  end
               end
            end else begin
               status = STATUS_BAD_DIGIT;
            end
         end
         OP_BLINK_ALL: begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
               blink_en_in[i]  = req_enable;
               blink_cnt_in[i] = BLINK_LOAD;
               phase_in[i]     = 1'b1;
            end
         end
         OP_BLINK_ONE: begin
            if (digit_ok) begin
               for (int i = 0; i < DIGIT_COUNT; i++) begin
                  blink_en_in[i]  = (req_digit == DIGIT_W'(i));
                  blink_cnt_in[i] = BLINK_LOAD;
                  phase_in[i]     = 1'b1;
               end
            end else begin
               status = STATUS_BAD_DIGIT;
            end
         end
         OP_STOP_BLINK: begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
               blink_en_in[i]  = 1'b0;
               blink_cnt_in[i] = BLINK_LOAD;
               phase_in[i]     = 1'b1;
            end
         end
         OP_ERASE: begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
               pattern_in[i] = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // Hold the display state; update it only on an accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            pattern_ff[i]   <= '0;
            blink_cnt_ff[i] <= BLINK_LOAD;
         end
         blink_en_ff <= '0;
         phase_ff    <= '1;
         cur_ff      <= '0;
         lit_ff      <= BRIGHT_RESET;
         win_ff      <= WIN_LOAD;
         seg_ff      <= '0;
         sel_ff      <= '0;
      end else if (accept) begin
         pattern_ff   <= pattern_in;
         blink_cnt_ff <= blink_cnt_in;
         blink_en_ff  <= blink_en_in;
         phase_ff     <= phase_in;
         cur_ff       <= cur_in;
         lit_ff       <= lit_in;
         win_ff       <= win_in;
         seg_ff       <= seg_in;
         sel_ff       <= sel_in;
      end
   end

   // Latch brightness from the register port.
   always_ff @(posedge clock) begin
      if (reset) begin
         bright_ff <= BRIGHT_RESET;
      end else if (csr_valid) begin
         bright_ff <= csr_wdata;
      end
   end

   // Form the response word from the pins as driven after this word.
   always_comb begin
      rsp_word.status   = status;
      rsp_word.select   = sel_in;
      rsp_word.segments = seg_in;
   end

   ssd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_ready  (req_tready),
      .in_word   (rsp_word),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (rsp_word_out)
   );

   assign rsp_tdata = {(RSP_DATA_W - $bits(rsp_word_type))'(0), rsp_word_out};

endmodule

`default_nettype wire
